FILE: hw/rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the battery cycle counter
// Direction codes, register indexes, reset values and the state record.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned DirW    = 2;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CountW-1:0] count_t;
  typedef logic [DirW-1:0]   dir_t;

  // Direction and phase codes.
  localparam dir_t DirIdle      = 2'd0;
  localparam dir_t DirCharge    = 2'd1;
  localparam dir_t DirDischarge = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgChgThr   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDisThr   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChgDwell = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDisDwell = 2'd3;

  localparam count_t ThrReset   = 16'd1000;
  localparam count_t DwellReset = 16'd7500;
  localparam count_t CountMax   = 16'hFFFF;

  typedef struct packed {
    count_t chg_dwell;
    count_t dis_dwell;
    dir_t   phase;
    logic   latched;
    count_t chg_count;
    count_t dis_count;
  } state_t;

  typedef struct packed {
    count_t chg_thr;
    count_t dis_thr;
    count_t chg_limit;
    count_t dis_limit;
  } cfg_t;

  function automatic count_t sat_inc(count_t v);
    return (v == CountMax) ? v : count_t'(v + 1'b1);
  endfunction

endpackage

FILE: hw/rtl/battery_cycle_counter_top.sv
// ----------------------------------------------------------------------------
// battery_cycle_counter_top: charge/discharge cycle counter
// Counts qualified charge and discharge phases of a battery pack per tick.
// ----------------------------------------------------------------------------
// One tick request is taken per clock while the result side takes every
// result: the request is captured in an input register, and the combinational
// update of the counter state runs from that register and writes the state and
// result registers once the result register is free or being read. The loop
// through the state registers closes within that update. The user must write
// thresholds and dwell limits through the configuration port only while no tick
// is in flight; the block itself does not enforce this.
module battery_cycle_counter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bcc_pkg::CountW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bcc_pkg::DirW-1:0]     direction_i,
  input  logic [bcc_pkg::CountW-1:0]   current_ma_i,
  input  logic                         hold_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bcc_pkg::CountW-1:0]   charge_cycles_o,
  output logic [bcc_pkg::CountW-1:0]   discharge_cycles_o,
  output logic [bcc_pkg::DirW-1:0]     last_phase_o,
  output logic                         cycle_counted_o,
  output logic                         cycle_latched_o
);

  bcc_pkg::cfg_t   cfg_q;
  bcc_pkg::state_t state_q, state_d;
  logic            counted_d;

  logic            in_vld_q;
  bcc_pkg::dir_t   dir_q;
  bcc_pkg::count_t cur_q;
  logic            hold_q;

  logic            out_vld_q;
  logic            fire;

  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chg_thr   <= bcc_pkg::ThrReset;
      cfg_q.dis_thr   <= bcc_pkg::ThrReset;
      cfg_q.chg_limit <= bcc_pkg::DwellReset;
      cfg_q.dis_limit <= bcc_pkg::DwellReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bcc_pkg::CfgChgThr:   cfg_q.chg_thr   <= cfg_data_i;
        bcc_pkg::CfgDisThr:   cfg_q.dis_thr   <= cfg_data_i;
        bcc_pkg::CfgChgDwell: cfg_q.chg_limit <= cfg_data_i;
        bcc_pkg::CfgDisDwell: cfg_q.dis_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      dir_q  <= direction_i;
      cur_q  <= current_ma_i;
      hold_q <= hold_i;
    end
  end

  bcc_update u_update (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .direction_i  (dir_q),
    .current_ma_i (cur_q),
    .hold_i       (hold_q),
    .state_o      (state_d),
    .counted_o    (counted_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      charge_cycles_o    <= state_d.chg_count;
      discharge_cycles_o <= state_d.dis_count;
      last_phase_o       <= state_d.phase;
      cycle_counted_o    <= counted_d;
      cycle_latched_o    <= state_d.latched;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

FILE: hw/rtl/bcc_update.sv
// ----------------------------------------------------------------------------
// bcc_update: next-state logic for one tick
// Runs the dwell counter of the active direction, qualifies phases and
// counts cycles; idle clears the dwells and the latch, hold keeps everything.
// ----------------------------------------------------------------------------
module bcc_update (
  input  bcc_pkg::state_t state_i,
  input  bcc_pkg::cfg_t   cfg_i,
  input  bcc_pkg::dir_t   direction_i,
  input  bcc_pkg::count_t current_ma_i,
  input  logic            hold_i,
  output bcc_pkg::state_t state_o,
  output logic            counted_o
);

  logic            active;
  logic            is_chg;
  bcc_pkg::count_t thr;
  bcc_pkg::count_t limit;
  bcc_pkg::count_t dwell_cur;
  bcc_pkg::count_t dwell_new;
  bcc_pkg::count_t count_cur;
  bcc_pkg::count_t count_new;
  bcc_pkg::dir_t   opposite;
  logic            qualified;
  logic            count_hit;

  assign is_chg    = (direction_i == bcc_pkg::DirCharge);
  assign active    = is_chg || (direction_i == bcc_pkg::DirDischarge);
  assign thr       = is_chg ? cfg_i.chg_thr   : cfg_i.dis_thr;
  assign limit     = is_chg ? cfg_i.chg_limit : cfg_i.dis_limit;
  assign dwell_cur = is_chg ? state_i.chg_dwell : state_i.dis_dwell;
  assign count_cur = is_chg ? state_i.chg_count : state_i.dis_count;
  assign opposite  = is_chg ? bcc_pkg::DirDischarge : bcc_pkg::DirCharge;

  assign dwell_new = (current_ma_i > thr && !state_i.latched) ?
                     bcc_pkg::sat_inc(dwell_cur) : '0;
  assign qualified = (dwell_new >= limit);
  assign count_hit = qualified && (state_i.phase == opposite);
  assign count_new = count_hit ? bcc_pkg::sat_inc(count_cur) : count_cur;

  always_comb begin
    state_o   = state_i;
    counted_o = 1'b0;
    if (!hold_i) begin
      if (active) begin
        // The dwell of the other direction always restarts.
        state_o.chg_dwell = is_chg ? dwell_new : '0;
        state_o.dis_dwell = is_chg ? '0 : dwell_new;
        if (is_chg) begin
          state_o.chg_count = count_new;
        end else begin
          state_o.dis_count = count_new;
        end
        if (qualified && state_i.phase == bcc_pkg::DirIdle) begin
          state_o.phase = direction_i;
        end
        if (count_hit) begin
          state_o.phase   = direction_i;
          state_o.latched = 1'b1;
          counted_o       = 1'b1;
        end
      end else begin
        state_o.chg_dwell = '0;
        state_o.dis_dwell = '0;
        state_o.latched   = 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker: port-level checks of the battery cycle counter
// Watches the result channel and attaches to the top level by bind.
// ----------------------------------------------------------------------------
module bcc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [bcc_pkg::CountW-1:0] charge_cycles_o,
  input logic [bcc_pkg::CountW-1:0] discharge_cycles_o,
  input logic [bcc_pkg::DirW-1:0]   last_phase_o,
  input logic                       cycle_counted_o,
  input logic                       cycle_latched_o
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(charge_cycles_o)
      && $stable(discharge_cycles_o) && $stable(last_phase_o)
      && $stable(cycle_counted_o) && $stable(cycle_latched_o))
    else $error("stalled result changed");

  // Counting a cycle always sets the latch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cycle_counted_o |-> cycle_latched_o)
    else $error("cycle counted without latch");

  // A counted cycle always leaves a known phase behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cycle_counted_o |->
      (last_phase_o == bcc_pkg::DirCharge || last_phase_o == bcc_pkg::DirDischarge))
    else $error("cycle counted with unknown phase");

  // Once known, the phase never returns to unknown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_phase_o != bcc_pkg::DirIdle
      ##1 out_valid_o |-> last_phase_o != bcc_pkg::DirIdle)
    else $error("phase fell back to unknown");

endmodule

bind battery_cycle_counter_top bcc_checker u_bcc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .charge_cycles_o    (charge_cycles_o),
  .discharge_cycles_o (discharge_cycles_o),
  .last_phase_o       (last_phase_o),
  .cycle_counted_o    (cycle_counted_o),
  .cycle_latched_o    (cycle_latched_o)
);

FILE: test/tb_battery_cycle_counter_top.sv
// ----------------------------------------------------------------------------
// tb_battery_cycle_counter_top: regression for the battery cycle counter
// Sends tick requests through the valid/ready input, predicts every result
// in the bench and compares each accepted result field by field. Covers the
// directed corner cases, random phase sequences under several register
// settings, and input and output back-pressure.
// ----------------------------------------------------------------------------
module tb_battery_cycle_counter_top;

  // The unused direction code behaves as idle.
  localparam bcc_pkg::dir_t DirUnused   = 2'd3;
  localparam int            DrainCycles = 4;
  localparam int            RxHoldOff   = 300;
  localparam int            PrintCap    = 50;

  typedef struct packed {
    bcc_pkg::count_t chg_cycles;
    bcc_pkg::count_t dis_cycles;
    bcc_pkg::dir_t   phase;
    logic            counted;
    logic            latched;
  } tick_res_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [bcc_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [bcc_pkg::CountW-1:0]   cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [bcc_pkg::DirW-1:0]     direction_i = '0;
  logic [bcc_pkg::CountW-1:0]   current_ma_i = '0;
  logic                         hold_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [bcc_pkg::CountW-1:0]   charge_cycles_o;
  logic [bcc_pkg::CountW-1:0]   discharge_cycles_o;
  logic [bcc_pkg::DirW-1:0]     last_phase_o;
  logic                         cycle_counted_o;
  logic                         cycle_latched_o;

  battery_cycle_counter_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .direction_i        (direction_i),
    .current_ma_i       (current_ma_i),
    .hold_i             (hold_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .charge_cycles_o    (charge_cycles_o),
    .discharge_cycles_o (discharge_cycles_o),
    .last_phase_o       (last_phase_o),
    .cycle_counted_o    (cycle_counted_o),
    .cycle_latched_o    (cycle_latched_o)
  );

  // Bench copy of the counter state and its registers.
  bcc_pkg::state_t pack_st;
  bcc_pkg::cfg_t   pack_cfg;
  tick_res_t       pending_readings[$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  rx_hold_req  = 0;
  int  rx_hold_seen = 0;
  int  rx_stall     = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintCap) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Applies one tick to the bench state and returns the result it shows.
  function automatic tick_res_t count_tick(input bcc_pkg::dir_t d, input bcc_pkg::count_t cur,
                                           input logic h);
    tick_res_t       r;
    bcc_pkg::count_t thr;
    bcc_pkg::count_t lim;
    bcc_pkg::count_t dwell;
    bcc_pkg::dir_t   opposite;
    logic            counted;
    counted = 1'b0;
    if (!h) begin
      if (d == bcc_pkg::DirCharge || d == bcc_pkg::DirDischarge) begin
        thr      = (d == bcc_pkg::DirCharge) ? pack_cfg.chg_thr : pack_cfg.dis_thr;
        lim      = (d == bcc_pkg::DirCharge) ? pack_cfg.chg_limit : pack_cfg.dis_limit;
        dwell    = (d == bcc_pkg::DirCharge) ? pack_st.chg_dwell : pack_st.dis_dwell;
        opposite = (d == bcc_pkg::DirCharge) ? bcc_pkg::DirDischarge : bcc_pkg::DirCharge;
        if (cur > thr && !pack_st.latched) begin
          dwell = (dwell == bcc_pkg::CountMax) ? dwell : bcc_pkg::count_t'(dwell + 1);
        end else begin
          dwell = '0;
        end
        if (dwell >= lim) begin
          if (pack_st.phase == bcc_pkg::DirIdle) begin
            pack_st.phase = d;
          end else if (pack_st.phase == opposite) begin
            if (d == bcc_pkg::DirCharge) begin
              if (pack_st.chg_count != bcc_pkg::CountMax) pack_st.chg_count++;
            end else begin
              if (pack_st.dis_count != bcc_pkg::CountMax) pack_st.dis_count++;
            end
            pack_st.latched = 1'b1;
            pack_st.phase   = d;
            counted         = 1'b1;
          end
        end
        if (d == bcc_pkg::DirCharge) begin
          pack_st.chg_dwell = dwell;
          pack_st.dis_dwell = '0;
        end else begin
          pack_st.dis_dwell = dwell;
          pack_st.chg_dwell = '0;
        end
      end else begin
        pack_st.chg_dwell = '0;
        pack_st.dis_dwell = '0;
        pack_st.latched   = 1'b0;
      end
    end
    r.chg_cycles = pack_st.chg_count;
    r.dis_cycles = pack_st.dis_count;
    r.phase      = pack_st.phase;
    r.counted    = counted;
    r.latched    = pack_st.latched;
    return r;
  endfunction

  // Valid stays high after acceptance; the next call either reuses it or
  // drops it for a gap.
  task automatic send_tick(input bcc_pkg::dir_t d, input bcc_pkg::count_t cur, input logic h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    direction_i  <= d;
    current_ma_i <= cur;
    hold_i       <= h;
    do @(posedge clk_i); while (!in_ready_o);
    pending_readings.push_back(count_tick(d, cur, h));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all four registers one after another; only called when idle.
  task automatic set_config(input bcc_pkg::count_t c_thr, input bcc_pkg::count_t d_thr,
                            input bcc_pkg::count_t c_lim, input bcc_pkg::count_t d_lim);
    bcc_pkg::count_t vals[4];
    vals = '{c_thr, d_thr, c_lim, d_lim};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= i[bcc_pkg::CfgIdxW-1:0];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    pack_cfg.chg_thr   = c_thr;
    pack_cfg.dis_thr   = d_thr;
    pack_cfg.chg_limit = c_lim;
    pack_cfg.dis_limit = d_lim;
  endtask

  always @(posedge clk_i) begin : rx_side
    tick_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("result arrived with no request pending");
      end else begin
        want = pending_readings.pop_front();
        if (charge_cycles_o !== want.chg_cycles)
          report_mismatch($sformatf("charge_cycles %0d, expected %0d",
                                    charge_cycles_o, want.chg_cycles));
        if (discharge_cycles_o !== want.dis_cycles)
          report_mismatch($sformatf("discharge_cycles %0d, expected %0d",
                                    discharge_cycles_o, want.dis_cycles));
        if (last_phase_o !== want.phase)
          report_mismatch($sformatf("last_phase %0d, expected %0d",
                                    last_phase_o, want.phase));
        if (cycle_counted_o !== want.counted)
          report_mismatch($sformatf("cycle_counted %b, expected %b",
                                    cycle_counted_o, want.counted));
        if (cycle_latched_o !== want.latched)
          report_mismatch($sformatf("cycle_latched %b, expected %b",
                                    cycle_latched_o, want.latched));
      end
    end
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_stall     = RxHoldOff;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_stall = pick_gap();
    end
  end

  task automatic test_directed();
    // Reset values: current equal to the threshold, hold and the unused code.
    send_tick(bcc_pkg::DirIdle, 16'd0, 1'b0);
    send_tick(bcc_pkg::DirCharge, 16'd1000, 1'b0);
    send_tick(bcc_pkg::DirCharge, bcc_pkg::CountMax, 1'b1);
    send_tick(DirUnused, bcc_pkg::CountMax, 1'b0);
    wait_drained();
    set_config(16'd100, 16'd200, 16'd2, 16'd1);
    send_tick(bcc_pkg::DirCharge, 16'd101, 1'b0);
    send_tick(bcc_pkg::DirCharge, 16'd101, 1'b0);
    send_tick(bcc_pkg::DirCharge, 16'd100, 1'b0);
    send_tick(bcc_pkg::DirDischarge, 16'd201, 1'b0);
    send_tick(bcc_pkg::DirDischarge, bcc_pkg::CountMax, 1'b0);
    send_tick(bcc_pkg::DirCharge, bcc_pkg::CountMax, 1'b1);
    send_tick(DirUnused, 16'd0, 1'b0);
    send_tick(bcc_pkg::DirCharge, 16'd101, 1'b0);
    send_tick(bcc_pkg::DirCharge, 16'd101, 1'b0);
    send_tick(bcc_pkg::DirIdle, 16'd0, 1'b0);
    wait_drained();
    // A dwell limit of zero is met on every tick, latched or not.
    set_config(16'd0, bcc_pkg::CountMax, 16'd0, 16'd0);
    send_tick(bcc_pkg::DirDischarge, 16'd0, 1'b0);
    send_tick(bcc_pkg::DirDischarge, bcc_pkg::CountMax, 1'b0);
    send_tick(bcc_pkg::DirCharge, 16'd0, 1'b0);
    send_tick(bcc_pkg::DirCharge, 16'd1, 1'b0);
    send_tick(bcc_pkg::DirDischarge, 16'd0, 1'b0);
    wait_drained();
  endtask

  // Mostly runs of one direction above its threshold, mixed with idle,
  // the unused code, random currents and hold ticks.
  task automatic run_random_phase(input bcc_pkg::count_t c_thr, input bcc_pkg::count_t d_thr,
                                  input bcc_pkg::count_t c_lim, input bcc_pkg::count_t d_lim,
                                  input int n_items, input int pause_at,
                                  input bit hold_off);
    int              sent;
    int              kind;
    int              len;
    bcc_pkg::dir_t   d;
    bcc_pkg::count_t thr;
    bcc_pkg::count_t lim;
    bcc_pkg::count_t cur;
    wait_drained();
    set_config(c_thr, d_thr, c_lim, d_lim);
    if (hold_off) rx_hold_req++;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) d = bcc_pkg::DirCharge;
      else if (kind < 8) d = bcc_pkg::DirDischarge;
      else if (kind == 8) d = bcc_pkg::DirIdle;
      else d = DirUnused;
      thr = (d == bcc_pkg::DirCharge) ? c_thr : d_thr;
      lim = (d == bcc_pkg::DirCharge) ? c_lim : d_lim;
      if (d == bcc_pkg::DirCharge || d == bcc_pkg::DirDischarge)
        len = $urandom_range(1, (lim < 10) ? int'(lim) + 3 : 12);
      else
        len = $urandom_range(1, 2);
      repeat (len) begin
        if (sent == pause_at) wait_drained();
        if ((d == bcc_pkg::DirCharge || d == bcc_pkg::DirDischarge) &&
            thr != bcc_pkg::CountMax && $urandom_range(0, 9) < 8)
          cur = bcc_pkg::count_t'($urandom_range(32'hFFFF, int'(thr) + 1));
        else
          cur = bcc_pkg::count_t'($urandom);
        send_tick(d, cur, $urandom_range(0, 11) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_random_settings();
    run_random_phase(bcc_pkg::count_t'($urandom_range(0, 3000)),
                     bcc_pkg::count_t'($urandom_range(0, 3000)),
                     bcc_pkg::count_t'($urandom_range(1, 6)),
                     bcc_pkg::count_t'($urandom_range(1, 6)),
                     150, -1, 1'b0);
    run_random_phase(16'd0, 16'd0, 16'd1, 16'd1, 120, -1, 1'b0);
    run_random_phase(bcc_pkg::CountMax, 16'hFFFE, bcc_pkg::CountMax, 16'd2, 100, -1, 1'b0);
    run_random_phase(bcc_pkg::count_t'($urandom), bcc_pkg::count_t'($urandom),
                     bcc_pkg::count_t'($urandom_range(1, 12)),
                     bcc_pkg::count_t'($urandom_range(1, 12)),
                     150, -1, 1'b0);
  endtask

  // The receiver holds off long enough for the block to stall its input,
  // and halfway through the sender waits until every result is back.
  task automatic test_backpressure();
    run_random_phase(16'd500, 16'd800, 16'd3, 16'd2, 140, 70, 1'b1);
  endtask

  initial begin
    pack_st  = '0;
    pack_cfg = '{chg_thr: bcc_pkg::ThrReset, dis_thr: bcc_pkg::ThrReset,
                 chg_limit: bcc_pkg::DwellReset, dis_limit: bcc_pkg::DwellReset};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_settings();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_update.sv
hw/rtl/battery_cycle_counter_top.sv
hw/rtl/bcc_checker.sv
test/tb_battery_cycle_counter_top.sv
